// ===== rtl/tms_pkg.sv =====
// Shared types and codes for the tracking mode supervisor.
// Used by tms_core and tracking_mode_supervisor; no dependencies.
`default_nettype none

package tms_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned PixW  = 13;
  localparam int unsigned ThrW  = 12;

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_SEARCH   = 3'd1;
  localparam logic [2:0] MODE_HOLD     = 3'd2;
  localparam logic [2:0] MODE_COARSE   = 3'd3;
  localparam logic [2:0] MODE_FINE     = 3'd4;
  localparam logic [2:0] MODE_FAILSAFE = 3'd5;

  localparam logic [2:0] VIS_IDLE      = 3'd0;
  localparam logic [2:0] VIS_SEARCHING = 3'd1;
  localparam logic [2:0] VIS_CANDIDATE = 3'd2;
  localparam logic [2:0] VIS_LOST      = 3'd4;

  localparam logic [1:0] REG_STALE     = 2'd0;
  localparam logic [1:0] REG_HOLD      = 2'd1;
  localparam logic [1:0] REG_COARSE    = 2'd2;
  localparam logic [1:0] REG_PERIOD    = 2'd3;

  localparam logic [7:0] STEP_DEFAULT  = 8'd50;
  localparam logic [7:0] STEP_MAX      = 8'd200;

  localparam logic [CfgW-1:0] STALE_RST  = 16'd300;
  localparam logic [CfgW-1:0] HOLD_RST   = 16'd250;
  localparam logic [ThrW-1:0] COARSE_RST = 12'd120;
  localparam logic [CfgW-1:0] PERIOD_RST = 16'd50;

  typedef struct packed {
    logic [TimeW-1:0]       now_ms;
    logic                   report_present;
    logic [TimeW-1:0]       report_time_ms;
    logic                   target_ok;
    logic [2:0]             vision_mode;
    logic signed [PixW-1:0] error_x_px;
    logic signed [PixW-1:0] error_y_px;
  } tms_item_t;

  typedef struct packed {
    logic [CfgW-1:0] stale_timeout_ms;
    logic [CfgW-1:0] hold_window_ms;
    logic [ThrW-1:0] coarse_threshold_px;
    logic [CfgW-1:0] period_ms;
  } tms_cfg_t;

  typedef struct packed {
    logic [2:0]       current_mode;
    logic [TimeW-1:0] hold_start_ms;
    logic [TimeW-1:0] last_step_ms;
    logic [TimeW-1:0] last_ctrl_ms;
  } tms_state_t;

  typedef struct packed {
    logic       early;
    logic [2:0] mode;
    logic       clear_loops;
    logic       track_active;
    logic [7:0] step_ms;
    tms_state_t state_next;
  } tms_step_t;

endpackage

`default_nettype wire

// ===== rtl/tms_core.sv =====
// Mode decision for one tick: period gate, mode pick, clear and step length.
// Depends on tms_pkg.
`default_nettype none

module tms_core (
  input  var tms_pkg::tms_item_t  item,
  input  var tms_pkg::tms_cfg_t   cfg,
  input  var tms_pkg::tms_state_t state_cur,
  output var tms_pkg::tms_step_t  result
);
  import tms_pkg::*;

  logic [TimeW-1:0] since_step;
  logic [TimeW-1:0] report_age;
  logic [TimeW-1:0] hold_start_eff;
  logic [TimeW-1:0] hold_age;
  logic [TimeW-1:0] update_gap;
  logic [PixW-1:0]  mag_x;
  logic [PixW-1:0]  mag_y;
  logic [PixW-1:0]  thr_ext;
  logic             stale;
  logic             no_target;
  logic             lost;
  logic             hold_ok;
  logic             coarse;
  logic [2:0]       pick;
  logic [7:0]       step_len;
  logic             active;

  always_comb begin
    since_step = item.now_ms - state_cur.last_step_ms;
    report_age = item.now_ms - item.report_time_ms;
    stale      = report_age > {{(TimeW-CfgW){1'b0}}, cfg.stale_timeout_ms};
    no_target  = !item.target_ok || item.vision_mode == VIS_SEARCHING ||
                 item.vision_mode == VIS_IDLE;
    lost       = item.vision_mode == VIS_LOST;

    hold_start_eff = (state_cur.current_mode != MODE_HOLD) ? item.now_ms
                                                           : state_cur.hold_start_ms;
    hold_age = item.now_ms - hold_start_eff;
    hold_ok  = hold_age <= {{(TimeW-CfgW){1'b0}}, cfg.hold_window_ms};

    mag_x   = item.error_x_px[PixW-1] ? (PixW'(0) - $unsigned(item.error_x_px))
                                      : $unsigned(item.error_x_px);
    mag_y   = item.error_y_px[PixW-1] ? (PixW'(0) - $unsigned(item.error_y_px))
                                      : $unsigned(item.error_y_px);
    thr_ext = {{(PixW-ThrW){1'b0}}, cfg.coarse_threshold_px};
    coarse  = mag_x > thr_ext || mag_y > thr_ext || item.vision_mode == VIS_CANDIDATE;

    if (stale) begin
      pick = MODE_FAILSAFE;
    end else if (no_target) begin
      pick = MODE_SEARCH;
    end else if (lost) begin
      pick = hold_ok ? MODE_HOLD : MODE_SEARCH;
    end else if (coarse) begin
      pick = MODE_COARSE;
    end else begin
      pick = MODE_FINE;
    end

    update_gap = item.now_ms - state_cur.last_ctrl_ms;
    if (state_cur.last_ctrl_ms == '0 || update_gap == '0 ||
        update_gap > {{(TimeW-8){1'b0}}, STEP_MAX}) begin
      step_len = STEP_DEFAULT;
    end else begin
      step_len = update_gap[7:0];
    end

    active = pick == MODE_COARSE || pick == MODE_FINE;

    result.early                   = since_step < {{(TimeW-CfgW){1'b0}}, cfg.period_ms};
    result.state_next              = state_cur;
    result.state_next.last_step_ms = item.now_ms;

    if (!item.report_present) begin
      result.mode                    = MODE_SEARCH;
      result.clear_loops             = 1'b1;
      result.track_active            = 1'b0;
      result.step_ms                 = STEP_DEFAULT;
      result.state_next.current_mode = MODE_SEARCH;
    end else begin
      result.mode                    = pick;
      result.clear_loops             = (pick != state_cur.current_mode) || !active;
      result.track_active            = active;
      result.step_ms                 = step_len;
      result.state_next.current_mode = pick;
      result.state_next.last_ctrl_ms = item.now_ms;
      if (!stale && !no_target && lost) begin
        result.state_next.hold_start_ms = hold_start_eff;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tracking_mode_supervisor.sv =====
// Tracking mode supervisor: one tick per cycle, at most one result per tick.
// An accepted tick goes to the input stage register; its result then raises out_valid.
// Throughput: one tick per cycle; the input stage and the result register are
// decoupled, so a waiting result stalls input only once both stages are full.
// Reset (rst, synchronous): registers to defaults, mode idle, all times zero.
// Depends on tms_pkg and tms_core.
`default_nettype none

module tracking_mode_supervisor (
  input  var logic                              clk,
  input  var logic                              rst,
  input  var logic                              cfg_we,
  input  var logic [1:0]                        cfg_index,
  input  var logic [tms_pkg::CfgW-1:0]          cfg_data,
  input  var logic                              in_valid,
  output var logic                              in_ready,
  input  var logic [tms_pkg::TimeW-1:0]         now_ms,
  input  var logic                              report_present,
  input  var logic [tms_pkg::TimeW-1:0]         report_time_ms,
  input  var logic                              target_ok,
  input  var logic [2:0]                        vision_mode,
  input  var logic signed [tms_pkg::PixW-1:0]   error_x_px,
  input  var logic signed [tms_pkg::PixW-1:0]   error_y_px,
  output var logic                              out_valid,
  input  var logic                              out_ready,
  output var logic [2:0]                        mode,
  output var logic                              clear_loops,
  output var logic                              track_active,
  output var logic [7:0]                        step_ms
);
  import tms_pkg::*;

  tms_cfg_t   cfg;
  tms_state_t state_cur;
  tms_item_t  stage;
  logic       stage_valid;
  tms_step_t  decision;
  logic       fire;

  assign fire     = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || fire;

  tms_core u_core (
    .item      (stage),
    .cfg       (cfg),
    .state_cur (state_cur),
    .result    (decision)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stale_timeout_ms    <= STALE_RST;
      cfg.hold_window_ms      <= HOLD_RST;
      cfg.coarse_threshold_px <= COARSE_RST;
      cfg.period_ms           <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STALE:  cfg.stale_timeout_ms    <= cfg_data;
        REG_HOLD:   cfg.hold_window_ms      <= cfg_data;
        REG_COARSE: cfg.coarse_threshold_px <= cfg_data[ThrW-1:0];
        REG_PERIOD: cfg.period_ms           <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      stage.now_ms         <= now_ms;
      stage.report_present <= report_present;
      stage.report_time_ms <= report_time_ms;
      stage.target_ok      <= target_ok;
      stage.vision_mode    <= vision_mode;
      stage.error_x_px     <= error_x_px;
      stage.error_y_px     <= error_y_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_cur.current_mode  <= MODE_IDLE;
      state_cur.hold_start_ms <= '0;
      state_cur.last_step_ms  <= '0;
      state_cur.last_ctrl_ms  <= '0;
      out_valid               <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire && !decision.early) begin
        state_cur <= decision.state_next;
        out_valid <= 1'b1;
      end
    end
    if (fire && !decision.early) begin
      mode         <= decision.mode;
      clear_loops  <= decision.clear_loops;
      track_active <= decision.track_active;
      step_ms      <= decision.step_ms;
    end
  end

  a_active_mode : assert property (@(posedge clk) disable iff (rst)
    out_valid && track_active |-> mode == MODE_COARSE || mode == MODE_FINE)
    else $error("track_active outside coarse or fine");

  a_clear_idle : assert property (@(posedge clk) disable iff (rst)
    out_valid && !track_active |-> clear_loops)
    else $error("loops not cleared while inactive");

  a_step_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> step_ms != 8'd0 && step_ms <= STEP_MAX)
    else $error("step out of range");

  a_last_step : assert property (@(posedge clk) disable iff (rst)
    fire && !decision.early |=> state_cur.last_step_ms == $past(stage.now_ms))
    else $error("last step time not taken");

  a_mode_track : assert property (@(posedge clk) disable iff (rst)
    fire && !decision.early |=> state_cur.current_mode == mode)
    else $error("mode state and result disagree");

endmodule

`default_nettype wire

// ===== tb/tms_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the tracking mode supervisor: snoops config writes and both handshakes,
// predicts each control step and compares every output transaction field by field.
// Depends on tms_pkg.

module tms_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [tms_pkg::CfgW-1:0]         cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [tms_pkg::TimeW-1:0]        now_ms,
  input  logic                             report_present,
  input  logic [tms_pkg::TimeW-1:0]        report_time_ms,
  input  logic                             target_ok,
  input  logic [2:0]                       vision_mode,
  input  logic signed [tms_pkg::PixW-1:0]  error_x_px,
  input  logic signed [tms_pkg::PixW-1:0]  error_y_px,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [2:0]                       mode,
  input  logic                             clear_loops,
  input  logic                             track_active,
  input  logic [7:0]                       step_ms,
  output int                               fail_count,
  output int                               pending,
  output int                               predicted,
  output int                               checked
);
  import tms_pkg::*;

  typedef struct packed {
    logic [2:0] mode;
    logic       clear;
    logic       active;
    logic [7:0] step;
  } mode_step_t;

  mode_step_t       expected_steps[$];
  logic [CfgW-1:0]  stale_lim;
  logic [CfgW-1:0]  hold_win;
  logic [ThrW-1:0]  coarse_thr;
  logic [CfgW-1:0]  period;
  logic [2:0]       cur_mode;
  logic [TimeW-1:0] hold_start;
  logic [TimeW-1:0] last_step;
  logic [TimeW-1:0] last_update;
  tms_item_t        tick;
  int               errors = 0;
  int               n_predicted = 0;
  int               n_checked = 0;

  function automatic logic [PixW-1:0] pixel_magnitude(input logic [PixW-1:0] e);
    return e[PixW-1] ? (~e + 1'b1) : e;
  endfunction

  task automatic predict_mode_step(input tms_item_t it);
    logic [2:0]       nxt;
    logic             clr;
    logic             act;
    logic [TimeW-1:0] dt;
    mode_step_t       r;
    if (it.now_ms - last_step < {16'd0, period}) return;
    last_step = it.now_ms;
    n_predicted++;
    if (!it.report_present) begin
      cur_mode = MODE_SEARCH;
      r.mode = MODE_SEARCH;
      r.clear = 1'b1;
      r.active = 1'b0;
      r.step = STEP_DEFAULT;
      expected_steps.push_back(r);
      return;
    end
    if (it.now_ms - it.report_time_ms > {16'd0, stale_lim}) begin
      nxt = MODE_FAILSAFE;
    end else if (!it.target_ok || it.vision_mode == VIS_SEARCHING ||
                 it.vision_mode == VIS_IDLE) begin
      nxt = MODE_SEARCH;
    end else if (it.vision_mode == VIS_LOST) begin
      if (cur_mode != MODE_HOLD) hold_start = it.now_ms;
      nxt = (it.now_ms - hold_start <= {16'd0, hold_win}) ? MODE_HOLD : MODE_SEARCH;
    end else if (pixel_magnitude(it.error_x_px) > {1'b0, coarse_thr} ||
                 pixel_magnitude(it.error_y_px) > {1'b0, coarse_thr} ||
                 it.vision_mode == VIS_CANDIDATE) begin
      nxt = MODE_COARSE;
    end else begin
      nxt = MODE_FINE;
    end
    clr = (nxt != cur_mode);
    cur_mode = nxt;
    if (last_update == '0) begin
      r.step = STEP_DEFAULT;
    end else begin
      dt = it.now_ms - last_update;
      r.step = (dt == '0 || dt > {24'd0, STEP_MAX}) ? STEP_DEFAULT : dt[7:0];
    end
    last_update = it.now_ms;
    act = (nxt == MODE_COARSE || nxt == MODE_FINE);
    r.mode = nxt;
    r.clear = clr | ~act;
    r.active = act;
    expected_steps.push_back(r);
  endtask

  task automatic compare_result();
    mode_step_t want;
    if (expected_steps.size() == 0) begin
      $display("%0t: unexpected result transaction, mode %0d", $time, mode);
      errors++;
      return;
    end
    want = expected_steps.pop_front();
    n_checked++;
    if (mode !== want.mode) begin
      $display("%0t: mode expected %0d got %0d", $time, want.mode, mode);
      errors++;
    end
    if (clear_loops !== want.clear) begin
      $display("%0t: clear_loops expected %0d got %0d", $time, want.clear, clear_loops);
      errors++;
    end
    if (track_active !== want.active) begin
      $display("%0t: track_active expected %0d got %0d", $time, want.active, track_active);
      errors++;
    end
    if (step_ms !== want.step) begin
      $display("%0t: step_ms expected %0d got %0d", $time, want.step, step_ms);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stale_lim   = STALE_RST;
      hold_win    = HOLD_RST;
      coarse_thr  = COARSE_RST;
      period      = PERIOD_RST;
      cur_mode    = MODE_IDLE;
      hold_start  = '0;
      last_step   = '0;
      last_update = '0;
      expected_steps.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STALE:  stale_lim = cfg_data;
          REG_HOLD:   hold_win = cfg_data;
          REG_COARSE: coarse_thr = cfg_data[ThrW-1:0];
          REG_PERIOD: period = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) begin
        tick.now_ms         = now_ms;
        tick.report_present = report_present;
        tick.report_time_ms = report_time_ms;
        tick.target_ok      = target_ok;
        tick.vision_mode    = vision_mode;
        tick.error_x_px     = error_x_px;
        tick.error_y_px     = error_y_px;
        predict_mode_step(tick);
      end
    end
    fail_count <= errors;
    pending    <= expected_steps.size();
    predicted  <= n_predicted;
    checked    <= n_checked;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the tracking mode supervisor testbench: clock, reset, register programming,
// tick stimulus with random throttling on both channels, and the verdict.
// Depends on tms_pkg, tracking_mode_supervisor and tms_checker.

module tb_top;
  import tms_pkg::*;

  localparam logic [2:0] VIS_LOCKED      = 3'd3;
  localparam logic [2:0] VIS_ALIAS_FIRST = 3'd5;
  localparam int         DRAIN_CYCLES    = 6;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_index = REG_STALE;
  logic [CfgW-1:0]        cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [TimeW-1:0]       now_ms = '0;
  logic                   report_present = 1'b0;
  logic [TimeW-1:0]       report_time_ms = '0;
  logic                   target_ok = 1'b0;
  logic [2:0]             vision_mode = VIS_IDLE;
  logic signed [PixW-1:0] error_x_px = '0;
  logic signed [PixW-1:0] error_y_px = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [2:0]             mode;
  logic                   clear_loops;
  logic                   track_active;
  logic [7:0]             step_ms;
  int                     fail_count;
  int                     pending;
  int                     predicted;
  int                     checked;

  logic                   no_gaps = 1'b0;
  int unsigned            out_stall = 0;
  int unsigned            ticks_sent = 0;
  int unsigned            settings_used = 1;
  logic [TimeW-1:0]       t_now = '0;
  int unsigned            cfg_stale = STALE_RST;
  int unsigned            cfg_hold = HOLD_RST;
  int unsigned            cfg_coarse = COARSE_RST;
  int unsigned            cfg_period = PERIOD_RST;
  logic [2:0]             vis_cur = VIS_LOCKED;
  int unsigned            vis_left = 0;

  tracking_mode_supervisor i_dut (.*);
  tms_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Hold ready low for a random number of cycles after each result transaction.
  always @(posedge clk) begin : out_throttle
    int unsigned stall;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_ready && out_valid) begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready <= 1'b0;
        out_stall <= stall - 1;
      end
    end else if (!out_ready) begin
      if (out_stall == 0) out_ready <= 1'b1;
      else out_stall <= out_stall - 1;
    end
  end

  task automatic send_tick(input tms_item_t it);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    now_ms         <= it.now_ms;
    report_present <= it.report_present;
    report_time_ms <= it.report_time_ms;
    target_ok      <= it.target_ok;
    vision_mode    <= it.vision_mode;
    error_x_px     <= it.error_x_px;
    error_y_px     <= it.error_y_px;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  task automatic tick(input logic [TimeW-1:0] t, input logic pres,
                      input logic [TimeW-1:0] rt, input logic valid,
                      input logic [2:0] vis, input int ex, input int ey);
    tms_item_t it;
    it.now_ms = t;
    it.report_present = pres;
    it.report_time_ms = rt;
    it.target_ok = valid;
    it.vision_mode = vis;
    it.error_x_px = PixW'(ex);
    it.error_y_px = PixW'(ey);
    send_tick(it);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_registers(input logic [CfgW-1:0] stale, hold, coarse, period);
    cfg_stale  = stale;
    cfg_hold   = hold;
    cfg_coarse = coarse[ThrW-1:0];
    cfg_period = period;
    cfg_we    <= 1'b1;
    cfg_index <= REG_STALE;
    cfg_data  <= stale;
    @(posedge clk);
    cfg_index <= REG_HOLD;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_index <= REG_COARSE;
    cfg_data  <= coarse;
    @(posedge clk);
    cfg_index <= REG_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [PixW-1:0] pick_error();
    int          m;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      m = int'(cfg_coarse) + int'($urandom_range(0, 4)) - 2;
      if (m < 0) m = 0;
    end else if (r < 70) begin
      m = $urandom_range(0, cfg_coarse);
    end else if (r < 90) begin
      return PixW'($urandom);
    end else begin
      case ($urandom_range(0, 2))
        0: return 13'h1000;
        1: return 13'h0fff;
        default: return 13'h1001;
      endcase
    end
    return $urandom_range(0, 1) ? PixW'(-m) : PixW'(m);
  endfunction

  task automatic make_random_tick(output tms_item_t it);
    int unsigned r;
    int unsigned age;
    r = $urandom_range(0, 99);
    if (r < 15) t_now += $urandom_range(0, cfg_period);
    else if (r < 75) t_now += cfg_period + $urandom_range(0, 60);
    else if (r < 90) t_now += $urandom_range(0, 400);
    else if (r < 97) t_now += cfg_period + $urandom_range(0, 70000);
    else t_now = $urandom;

    r = $urandom_range(0, 99);
    if (r < 30) age = $urandom_range(0, cfg_stale);
    else if (r < 45) age = cfg_stale;
    else if (r < 55) age = cfg_stale + 1;
    else if (r < 70) age = 0;
    else if (r < 85) age = $urandom_range(0, 3 * cfg_stale + 10);
    else age = $urandom;

    // Keep the vision state for a run of ticks so lost-hold windows can expire.
    if (vis_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 35) vis_cur = VIS_LOCKED;
      else if (r < 55) vis_cur = VIS_LOST;
      else if (r < 70) vis_cur = VIS_CANDIDATE;
      else if (r < 78) vis_cur = VIS_IDLE;
      else if (r < 86) vis_cur = VIS_SEARCHING;
      else vis_cur = VIS_ALIAS_FIRST + 3'($urandom_range(0, 2));
      vis_left = $urandom_range(1, 10);
    end
    vis_left--;

    it.now_ms         = t_now;
    it.report_present = ($urandom_range(0, 19) != 0);
    it.report_time_ms = t_now - age;
    it.target_ok      = ($urandom_range(0, 12) != 0);
    it.vision_mode    = vis_cur;
    it.error_x_px     = pick_error();
    it.error_y_px     = pick_error();
  endtask

  initial begin
    tms_item_t it;
    int        goal;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks against the reset register values.
    tick(0, 0, 0, 0, VIS_IDLE, 0, 0);
    tick(50, 1, 50, 1, VIS_LOCKED, 0, 0);
    tick(100, 1, 100, 1, VIS_LOCKED, 0, 0);
    tick(120, 1, 120, 1, VIS_LOCKED, 0, 0);
    tick(150, 1, 150, 1, VIS_CANDIDATE, 0, 0);
    tick(200, 1, 200, 1, VIS_LOCKED, 121, 0);
    tick(250, 1, 250, 1, VIS_LOCKED, -4096, 0);
    tick(300, 1, 300, 1, VIS_LOCKED, 0, 4095);
    tick(350, 1, 350, 1, VIS_LOCKED, 120, -120);
    tick(400, 1, 400, 1, VIS_LOST, 0, 0);
    tick(650, 1, 650, 1, VIS_LOST, 0, 0);
    tick(700, 1, 700, 1, VIS_LOST, 0, 0);
    tick(750, 1, 750, 1, VIS_IDLE, 0, 0);
    tick(800, 1, 800, 1, VIS_SEARCHING, 0, 0);
    tick(850, 1, 850, 0, VIS_LOCKED, 0, 0);
    tick(900, 1, 599, 1, VIS_LOCKED, 0, 0);
    tick(950, 1, 650, 1, VIS_LOCKED, -4095, 4095);
    tick(1000, 0, 1000, 1, VIS_LOCKED, 0, 0);
    tick(1300, 1, 1300, 1, VIS_ALIAS_FIRST, 0, 0);
    tick(1350, 1, 1350, 1, VIS_ALIAS_FIRST + 3'd1, 0, 0);
    tick(1400, 1, 1400, 1, VIS_ALIAS_FIRST + 3'd2, 0, 0);
    tick(32'hffff_fff0, 1, 32'hffff_fff0, 1, VIS_LOCKED, 0, 0);
    tick(32'h40, 1, 32'h40, 1, VIS_LOCKED, 0, 0);
    tick(0, 1, 0, 1, VIS_LOCKED, 0, 0);
    tick(60, 1, 100, 1, VIS_LOCKED, 0, 0);
    t_now = 60;

    for (int phase = 0; phase < 8; phase++) begin
      if (phase != 0) begin
        in_valid <= 1'b0;
        wait_drained();
        case (phase)
          2: program_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000);
          4: program_registers(16'hffff, 16'hffff, 16'hffff, 16'hffff);
          5: program_registers(CfgW'($urandom_range(100, 1000)),
                               CfgW'($urandom_range(50, 600)),
                               CfgW'($urandom_range(10, 400)),
                               CfgW'($urandom_range(0, 3)));
          default: program_registers(CfgW'($urandom_range(100, 1000)),
                                     CfgW'($urandom_range(50, 600)),
                                     CfgW'(32'hf000 | $urandom_range(10, 400)),
                                     CfgW'($urandom_range(20, 100)));
        endcase
      end
      no_gaps = (phase % 3 == 2);
      goal = predicted + 80;
      while (predicted < goal) begin
        make_random_tick(it);
        send_tick(it);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    $display("Sent %0d ticks over %0d register settings, %0d control steps compared",
             ticks_sent, settings_used, checked);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
